// File: src/escape_time_fractal_iterator_top_defines.svh
// Assertion macros for the escape-time fractal iterator.
// Included by the modules that check their own logic; depends on i_clk and i_rst_n.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_TOP_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ETF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("etf assertion failed");
// Next-cycle implication, disabled during reset
`define ETF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("etf assertion failed");
`else
`define ETF_ASSERT_IMP(label, ante, cons)
`define ETF_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/etf_pkg.sv
// Shared types and constants of the escape-time fractal iterator.
// No dependencies; imported by etf_mul, the top level and the testbench.
package etf_pkg;

    // Coordinate word: signed two's complement fixed point
    localparam int COORD_BITS = 32;
    // Digit width of the serial multiplier
    localparam int MUL_DIGIT_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int MODE_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_C_REAL   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_C_IMAG   = 2'd3;

    // Fractal mode codes; the unused code behaves as Mandelbrot
    localparam logic [MODE_BITS-1:0] MODE_MANDEL = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_JULIA  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BURN   = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_real;
        logic signed [COORD_BITS-1:0] point_imag;
    } t_point;

    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic                  escaped;
    } t_result;

    // Multiplier request: start, shift one bit less (2xy), return magnitude
    typedef struct packed {
        logic start;
        logic dbl;
        logic mag;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage

// File: src/etf_mul.sv
// Shared fixed-point multiplier: digit-serial magnitude product, truncating shift
// and saturation to the coordinate range. Depends on etf_pkg and the defines header.
`include "escape_time_fractal_iterator_top_defines.svh"
module etf_mul #(
    parameter int FRAC_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  etf_pkg::t_mul_req             i_req,
    input  logic [etf_pkg::COORD_BITS-1:0] i_op_a,
    input  logic [etf_pkg::COORD_BITS-1:0] i_op_b,
    output etf_pkg::t_mul_sts             o_sts,
    output logic [etf_pkg::COORD_BITS-1:0] o_prod
);
    import etf_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int DW   = MUL_DIGIT_BITS;
    localparam int ND   = (CW + DW - 1) / DW;
    localparam int BW   = ND * DW;
    localparam int AW   = 2 * CW;
    localparam int CNTW = $clog2(ND + 1);
    localparam logic [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};

    typedef enum logic [1:0] {MS_IDLE, MS_RUN, MS_FIN} t_mstate;

    t_mstate          r_state;
    logic [CNTW-1:0]  r_left;
    logic [CW-1:0]    r_a_mag;
    logic [BW-1:0]    r_b_mag;
    logic [AW-1:0]    r_acc;
    logic             r_neg;
    logic             r_dbl;
    logic             r_done;
    logic [CW-1:0]    r_prod;

    logic [CW-1:0]    a_mag;
    logic [CW-1:0]    b_mag;
    logic [CW+DW-1:0] part;
    logic [AW-1:0]    shifted;
    logic [CW-1:0]    lim;
    logic [CW-1:0]    mag_sat;
    logic [CW-1:0]    res;

    // Take operand magnitudes at start
    assign a_mag = i_op_a[CW-1] ? (~i_op_a + 1'b1) : i_op_a;
    assign b_mag = i_op_b[CW-1] ? (~i_op_b + 1'b1) : i_op_b;

    // One digit of b against all of a
    assign part = r_a_mag * r_b_mag[BW-1 -: DW];

    // Truncate toward zero, saturate, apply sign
    always_comb begin
        shifted = r_dbl ? (r_acc >> (FRAC_BITS - 1)) : (r_acc >> FRAC_BITS);
        lim     = QMAX + CW'(r_neg);
        mag_sat = (shifted > AW'(lim)) ? lim : shifted[CW-1:0];
        res     = r_neg ? (~mag_sat + 1'b1) : mag_sat;
    end

    // Sequence digits, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                MS_IDLE: begin
                    if (i_req.start) begin
                        r_a_mag <= a_mag;
                        r_b_mag <= BW'(b_mag);
                        r_acc   <= '0;
                        r_neg   <= (i_op_a[CW-1] ^ i_op_b[CW-1]) & ~i_req.mag;
                        r_dbl   <= i_req.dbl;
                        r_left  <= CNTW'(ND);
                        r_state <= MS_RUN;
                    end
                end
                MS_RUN: begin
                    r_acc   <= (r_acc << DW) + AW'(part);
                    r_b_mag <= r_b_mag << DW;
                    r_left  <= r_left - 1'b1;
                    if (r_left == CNTW'(1)) begin
                        r_state <= MS_FIN;
                    end
                end
                MS_FIN: begin
                    r_prod  <= res;
                    r_done  <= 1'b1;
                    r_state <= MS_IDLE;
                end
                default: begin
                    r_state <= MS_IDLE;
                end
            endcase
        end
    end

    assign o_sts.busy = (r_state != MS_IDLE);
    assign o_sts.done = r_done;
    assign o_prod     = r_prod;

    `ETF_ASSERT_NXT(a_done_pulse, r_done, !r_done)
    `ETF_ASSERT_NXT(a_fin_done, r_state == MS_FIN, r_done)
    `ETF_ASSERT_IMP(a_pos_nonneg, r_done && !r_neg, !r_prod[CW-1])

endmodule

// File: src/escape_time_fractal_iterator_top.sv
// Top level of the escape-time fractal iterator: configuration registers and
// the iteration sequencer around one shared etf_mul. Depends on etf_pkg, etf_mul.
//
// Usage:
//   Write configuration with i_cfg_we, i_cfg_index and i_cfg_wdata while idle:
//   index 0 fractal mode, 1 maximum count, 2 and 3 the Julia constant.
//   Present a point on i_point and raise start; the item is taken at the edge
//   where start is high and busy is low. busy stays high while the point runs.
//   The result appears on o_result for exactly one cycle with o_result_valid
//   high; the receiver cannot stall, so it must take it in that cycle.
//   Each iteration runs three products through the single digit-serial
//   multiplier (ND = ceil(32 / 16) = 2 digits of 16 bits, a finish step
//   and a handoff for each), plus the bound check and the escape test.
//   A point that stops at the bound raises the strobe from the bound
//   check; one that escapes raises it from the escape test. busy drops
//   with the result strobe, and a new point may be accepted in that cycle.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle, drops
//   any point in flight and loads the register defaults: Mandelbrot, 256
//   iterations, Julia constant -0.7 + 0.27015i.
`include "escape_time_fractal_iterator_top_defines.svh"
module escape_time_fractal_iterator_top #(
    parameter int FRAC_BITS = 28
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [etf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [etf_pkg::COORD_BITS-1:0]    i_cfg_wdata,
    input  logic                              start,
    input  etf_pkg::t_point                   i_point,
    output logic                              busy,
    output logic                              o_result_valid,
    output etf_pkg::t_result                  o_result
);
    import etf_pkg::*;

    localparam int CW = COORD_BITS;
    localparam logic [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW:0]   FOUR = (CW+1)'(4) << FRAC_BITS;

    // Julia constant defaults, truncated toward zero
    localparam logic [63:0] ONE      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] C_RE_MAG = (64'd7 * ONE) / 64'd10;
    localparam logic [63:0] C_RE_NEG = 64'd0 - C_RE_MAG;
    localparam logic [63:0] C_IM_VAL = (ONE / 64'd100000) * 64'd27015
                                     + ((ONE % 64'd100000) * 64'd27015) / 64'd100000;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SQ_X, S_SQ_Y, S_ESC, S_XY} t_state;

    t_state                r_state;
    logic [MODE_BITS-1:0]  r_mode;
    logic [COUNT_BITS-1:0] r_max_iter;
    logic [CW-1:0]         r_jc_re;
    logic [CW-1:0]         r_jc_im;
    logic [CW-1:0]         r_x;
    logic [CW-1:0]         r_y;
    logic [CW-1:0]         r_cr;
    logic [CW-1:0]         r_ci;
    logic [CW-1:0]         r_x2;
    logic [CW-1:0]         r_y2;
    logic [CW-1:0]         r_diff;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_out_valid;
    t_result               r_out;

    t_mul_req              mul_req;
    t_mul_sts              mul_sts;
    logic [CW-1:0]         mul_a;
    logic [CW-1:0]         mul_b;
    logic [CW-1:0]         mul_prod;
    logic                  accept;
    logic                  below_max;
    logic                  escape;

    // Saturate a one-bit-wider sum to the coordinate range
    function automatic logic [CW-1:0] sat_wide(input logic [CW:0] s);
        if (s[CW] != s[CW-1]) begin
            return s[CW] ? QMIN : QMAX;
        end
        return s[CW-1:0];
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_MANDEL;
            r_max_iter <= COUNT_BITS'(256);
            r_jc_re    <= C_RE_NEG[CW-1:0];
            r_jc_im    <= C_IM_VAL[CW-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_mode     <= i_cfg_wdata[MODE_BITS-1:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_wdata[COUNT_BITS-1:0];
                CFG_C_REAL:   r_jc_re    <= i_cfg_wdata;
                CFG_C_IMAG:   r_jc_im    <= i_cfg_wdata;
            endcase
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign below_max = (r_count < r_max_iter);
    // Squares are never negative, so the saturating sum compares the same
    assign escape    = (({1'b0, r_x2} + {1'b0, r_y2}) > FOUR);

    // Drive the shared multiplier: x*x, then y*y, then 2xy
    always_comb begin
        mul_req.start = ((r_state == S_CHECK) && below_max)
                     || ((r_state == S_SQ_X) && mul_sts.done)
                     || ((r_state == S_ESC) && !escape);
        mul_req.dbl   = (r_state == S_ESC);
        mul_req.mag   = (r_state == S_ESC) && (r_mode == MODE_BURN);
        mul_a         = (r_state == S_SQ_X) ? r_y : r_x;
        mul_b         = (r_state == S_CHECK) ? r_x : r_y;
    end

    etf_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_op_a  (mul_a),
        .i_op_b  (mul_b),
        .o_sts   (mul_sts),
        .o_prod  (mul_prod)
    );

    // Sequence one point through its iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= '0;
                        if (r_mode == MODE_JULIA) begin
                            r_x  <= i_point.point_real;
                            r_y  <= i_point.point_imag;
                            r_cr <= r_jc_re;
                            r_ci <= r_jc_im;
                        end else begin
                            r_x  <= '0;
                            r_y  <= '0;
                            r_cr <= i_point.point_real;
                            r_ci <= i_point.point_imag;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (below_max) begin
                        r_state <= S_SQ_X;
                    end else begin
                        r_out.iteration_count <= r_count;
                        r_out.escaped         <= 1'b0;
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                S_SQ_X: begin
                    if (mul_sts.done) begin
                        r_x2    <= mul_prod;
                        r_state <= S_SQ_Y;
                    end
                end
                S_SQ_Y: begin
                    if (mul_sts.done) begin
                        r_y2    <= mul_prod;
                        r_state <= S_ESC;
                    end
                end
                S_ESC: begin
                    if (escape) begin
                        r_out.iteration_count <= r_count;
                        r_out.escaped         <= 1'b1;
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end else begin
                        r_diff  <= sat_wide({r_x2[CW-1], r_x2} - {r_y2[CW-1], r_y2});
                        r_state <= S_XY;
                    end
                end
                S_XY: begin
                    if (mul_sts.done) begin
                        r_x     <= sat_wide({r_diff[CW-1], r_diff} + {r_cr[CW-1], r_cr});
                        r_y     <= sat_wide({mul_prod[CW-1], mul_prod} + {r_ci[CW-1], r_ci});
                        r_count <= r_count + 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    `ETF_ASSERT_NXT(a_accept_busy, accept, busy)
    `ETF_ASSERT_IMP(a_mul_free, mul_req.start, !mul_sts.busy)
    `ETF_ASSERT_IMP(a_count_bound, o_result_valid, o_result.iteration_count <= r_max_iter)
    `ETF_ASSERT_IMP(a_escape_below, o_result_valid && o_result.escaped,
                    o_result.iteration_count < r_max_iter)

endmodule

// File: tb/escape_time_fractal_iterator_top_tb.sv
// Self-checking testbench for escape_time_fractal_iterator_top: directed points, then
// phases of random points under changing mode, bound and Julia constant settings.
// Depends on etf_pkg and the top level; checks against table rows or a fixed-point predictor.
`timescale 1ns / 100ps

module escape_time_fractal_iterator_top_tb;
    import etf_pkg::*;

    localparam int FRAC_BITS = 28;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint FOUR_Q = longint'(4) <<< FRAC_BITS;
    localparam int Q_ONE = 1 << FRAC_BITS;
    localparam logic [15:0] DEF_MAX_ITER = 16'd256;

    // One directed point; count and flag are used only when typed is set
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        bit                 typed;
        logic [15:0]        count;
        logic               esc;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [17] = '{
        '{32'sd0,           32'sd0,           1'b1, DEF_MAX_ITER, 1'b0},  // origin stays
        '{32'sh7FFF_FFFF,   32'sh7FFF_FFFF,   1'b1, 16'd1,        1'b1},
        '{32'sh8000_0000,   32'sh8000_0000,   1'b1, 16'd1,        1'b1},
        '{32'sh8000_0000,   32'sh7FFF_FFFF,   1'b1, 16'd1,        1'b1},
        '{32'sh7FFF_FFFF,   32'sh8000_0000,   1'b1, 16'd1,        1'b1},
        '{32'sd805306368,   32'sd0,           1'b1, 16'd1,        1'b1},  // 3.0
        '{-32'sd536870912,  32'sd0,           1'b1, DEF_MAX_ITER, 1'b0},  // -2 sits on |z| = 2
        '{32'sd0,           32'sd268435456,   1'b1, DEF_MAX_ITER, 1'b0},  // i is periodic
        '{-32'sd268435456,  32'sd0,           1'b1, DEF_MAX_ITER, 1'b0},  // -1 is periodic
        '{32'sd536870912,   32'sd0,           1'b1, 16'd2,        1'b1},  // 2.0
        '{32'sd0,           32'sd536870912,   1'b1, 16'd2,        1'b1},  // 2.0i
        '{32'sd67108864,    32'sd0,           1'b0, 16'd0,        1'b0},  // cusp
        '{-32'sd201326592,  32'sd26843545,    1'b0, 16'd0,        1'b0},
        '{32'sd134217728,   32'sd134217728,   1'b0, 16'd0,        1'b0},
        '{32'sd1,           32'sd1,           1'b0, 16'd0,        1'b0},
        '{-32'sd469762048,  32'sd0,           1'b0, 16'd0,        1'b0},
        '{-32'sd26843545,   32'sd241591910,   1'b0, 16'd0,        1'b0}
    };

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = CFG_MODE;
    logic [COORD_BITS-1:0]   i_cfg_wdata = '0;
    logic    start = 1'b0;
    t_point  i_point = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    // Mirror of the block's registers, starting at their reset values
    logic [1:0]         cfg_mode = MODE_MANDEL;
    logic [15:0]        cfg_max_iter = DEF_MAX_ITER;
    logic signed [31:0] cfg_c_real = -32'sd187904819;
    logic signed [31:0] cfg_c_imag = 32'sd72517838;

    t_result pending_results [$];
    int      mismatch_count = 0;

    escape_time_fractal_iterator_top #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .i_point       (i_point),
        .busy          (busy),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > Q_MAX) return Q_MAX;
        if (s < Q_MIN) return Q_MIN;
        return s;
    endfunction

    // Exact product, magnitude truncated by shift, sign restored, saturated
    function automatic longint scaled_product(longint a, longint b, int shift);
        bit neg;
        longint unsigned ua, ub, mag, lim;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        mag = (ua * ub) >> shift;
        lim = Q_MAX + (neg ? 1 : 0);
        if (mag > lim) mag = lim;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Iterate one point under the mirrored settings
    function automatic t_result escape_time_of(t_point p);
        longint x, y, cr, ci, x2, y2, xy;
        int count;
        t_result r;
        if (cfg_mode == MODE_JULIA) begin
            x = $signed(p.point_real);
            y = $signed(p.point_imag);
            cr = cfg_c_real;
            ci = cfg_c_imag;
        end else begin
            x = 0;
            y = 0;
            cr = $signed(p.point_real);
            ci = $signed(p.point_imag);
        end
        count = 0;
        r.escaped = 1'b0;
        while (count < int'(cfg_max_iter)) begin
            x2 = scaled_product(x, x, FRAC_BITS);
            y2 = scaled_product(y, y, FRAC_BITS);
            if (sat_sum(x2, y2) > FOUR_Q) begin
                r.escaped = 1'b1;
                break;
            end
            xy = scaled_product(x, y, FRAC_BITS - 1);
            // burning ship folds the cross term to its magnitude
            if (cfg_mode == MODE_BURN && xy < 0) xy = (xy == Q_MIN) ? Q_MAX : -xy;
            x = sat_sum(sat_sum(x2, -y2), cr);
            y = sat_sum(xy, ci);
            count++;
        end
        r.iteration_count = count[15:0];
        return r;
    endfunction

    // Mostly points near the sets, some wider, some raw words
    function automatic t_point random_point(bit far_only);
        t_point p;
        int sel;
        sel = $urandom_range(0, 99);
        if (far_only) begin
            // |re| above 2.25 escapes on the first step in Mandelbrot mode
            p.point_real = int'($urandom_range(603979776, 2147483647));
            if ($urandom_range(0, 1)) p.point_real = -p.point_real - 1;
            p.point_imag = $urandom();
        end else if (sel < 70) begin
            p.point_real = int'($urandom_range(0, 872415232)) - 603979776;
            p.point_imag = int'($urandom_range(0, 805306368)) - 402653184;
        end else if (sel < 85) begin
            p.point_real = int'($urandom_range(0, 1342177280)) - 671088640;
            p.point_imag = int'($urandom_range(0, 1342177280)) - 671088640;
        end else begin
            p.point_real = $urandom();
            p.point_imag = $urandom();
        end
        return p;
    endfunction

    // Mostly short gaps, a few long
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 20);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic signed [31:0] random_constant();
        if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        return $urandom();
    endfunction

    // Drive one register write; the caller drops the enable after the last one
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:     cfg_mode = data[1:0];
            CFG_MAX_ITER: cfg_max_iter = data[15:0];
            CFG_C_REAL:   cfg_c_real = data;
            CFG_C_IMAG:   cfg_c_imag = data;
        endcase
    endtask

    // Hold until every outstanding item has reported
    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Present one item after a gap and wait for it to be taken
    task automatic send_point(t_point p, t_result want, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_point <= p;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(want);
    endtask

    // Reprogram all registers, then stream random points
    task automatic run_phase(logic [1:0] mode, logic [15:0] max_iter,
                             logic signed [31:0] c_re, logic signed [31:0] c_im,
                             int n_items, bit far_only, bit no_gaps);
        t_point p;
        wait_idle();
        // junk in the unused upper bits must be ignored
        write_reg(CFG_MODE, ($urandom() & ~32'h3) | 32'(mode));
        write_reg(CFG_MAX_ITER, ($urandom() & 32'hFFFF_0000) | 32'(max_iter));
        write_reg(CFG_C_REAL, c_re);
        write_reg(CFG_C_IMAG, c_im);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < n_items; k++) begin
            p = random_point(far_only);
            send_point(p, escape_time_of(p), no_gaps ? 0 : idle_cycles());
        end
        start <= 1'b0;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: count %0d escaped %0b",
                       o_result.iteration_count, o_result.escaped);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.iteration_count !== want.iteration_count) begin
                    $error("iteration_count: expected %0d, got %0d",
                           want.iteration_count, o_result.iteration_count);
                    mismatch_count++;
                end
                if (o_result.escaped !== want.escaped) begin
                    $error("escaped: expected %0b, got %0b", want.escaped, o_result.escaped);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_point  p;
        t_result want;
        logic [15:0] max_iter;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points under reset settings
        foreach (DIRECTED_ROWS[k]) begin
            p.point_real = DIRECTED_ROWS[k].re;
            p.point_imag = DIRECTED_ROWS[k].im;
            if (DIRECTED_ROWS[k].typed) begin
                want.iteration_count = DIRECTED_ROWS[k].count;
                want.escaped = DIRECTED_ROWS[k].esc;
            end else begin
                want = escape_time_of(p);
            end
            send_point(p, want, idle_cycles());
        end
        start <= 1'b0;

        // Julia with the reset constant: switch the mode only
        wait_idle();
        write_reg(CFG_MODE, 32'(MODE_JULIA));
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 6; k++) begin
            p = random_point(1'b0);
            send_point(p, escape_time_of(p), idle_cycles());
        end
        start <= 1'b0;

        // Fixed settings: zero bound, extreme constants, unused mode, burning ship, full bound
        run_phase(MODE_MANDEL, 16'd0, random_constant(), random_constant(), 12, 1'b0, 1'b0);
        run_phase(MODE_JULIA, 16'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 20, 1'b0, 1'b1);
        run_phase(2'd3, 16'd24, random_constant(), random_constant(), 60, 1'b0, 1'b0);
        run_phase(MODE_BURN, DEF_MAX_ITER, random_constant(), random_constant(),
                  8, 1'b0, 1'b0);
        run_phase(MODE_JULIA, DEF_MAX_ITER, random_constant(), random_constant(),
                  8, 1'b0, 1'b0);
        run_phase(MODE_MANDEL, 16'hFFFF, random_constant(), random_constant(), 10, 1'b1, 1'b0);
        run_phase(MODE_JULIA, 16'd5, 32'sh7FFF_FFFF, 32'sh8000_0000, 20, 1'b0, 1'b0);

        // Random settings
        for (int ph = 0; ph < 16; ph++) begin
            if ($urandom_range(0, 9) == 0) max_iter = 16'($urandom_range(0, 3));
            else max_iter = 16'($urandom_range(4, 40));
            run_phase(2'($urandom_range(0, 3)), max_iter, random_constant(),
                      random_constant(), 50, 1'b0, $urandom_range(0, 3) == 0);
        end

        // Drain, then watch for stray results
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[escape_time_fractal_iterator_top] OK");
        end else begin
            $display("[escape_time_fractal_iterator_top] ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #40_000_000;
        $display("[escape_time_fractal_iterator_top] ERROR");
        $finish;
    end

endmodule
